// File: rtl/stree_pkg.sv
// Shared types, constants and the microcode program of the segment tree sum block.
package stree_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Register indexes on the configuration port.
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    // Datapath operations selected by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_ACCEPT,
        OP_WLEAF,
        OP_WUP,
        OP_QINIT,
        OP_QSTEP,
        OP_OUT_SUM,
        OP_OUT_ERR
    } op_t;

    // What a step waits on before it executes.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } hold_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CLR_MORE,
        COND_QUERY,
        COND_BAD,
        COND_NOT_TOP,
        COND_L_LT_R
    } cond_t;

    typedef struct packed {
        op_t   op;
        hold_t hold;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic go;
        logic restart;
    } dp_ctrl_t;

    typedef struct packed {
        logic clr_more;
        logic is_query;
        logic bad;
        logic not_top;
        logic l_lt_r;
    } dp_status_t;

    localparam step_t ST_CLR   = 4'd0;
    localparam step_t ST_IDLE  = 4'd1;
    localparam step_t ST_DISP  = 4'd2;
    localparam step_t ST_WCHK  = 4'd3;
    localparam step_t ST_WLEAF = 4'd4;
    localparam step_t ST_WUP   = 4'd5;
    localparam step_t ST_WEND  = 4'd6;
    localparam step_t ST_QINIT = 4'd7;
    localparam step_t ST_QLVL  = 4'd8;
    localparam step_t ST_QOUT  = 4'd9;
    localparam step_t ST_QERR  = 4'd10;

    // The control program: one word per step.
    function automatic uword_t ucode_rom(step_t step);
        uword_t w;
        case (step)
            ST_CLR:   w = '{OP_CLR,     HOLD_NONE, COND_CLR_MORE, ST_CLR};
            ST_IDLE:  w = '{OP_ACCEPT,  HOLD_IN,   COND_NEVER,    ST_IDLE};
            ST_DISP:  w = '{OP_NOP,     HOLD_NONE, COND_QUERY,    ST_QINIT};
            ST_WCHK:  w = '{OP_NOP,     HOLD_NONE, COND_BAD,      ST_IDLE};
            ST_WLEAF: w = '{OP_WLEAF,   HOLD_NONE, COND_NEVER,    ST_IDLE};
            ST_WUP:   w = '{OP_WUP,     HOLD_NONE, COND_NOT_TOP,  ST_WUP};
            ST_WEND:  w = '{OP_NOP,     HOLD_NONE, COND_ALWAYS,   ST_IDLE};
            ST_QINIT: w = '{OP_QINIT,   HOLD_NONE, COND_BAD,      ST_QERR};
            ST_QLVL:  w = '{OP_QSTEP,   HOLD_NONE, COND_L_LT_R,   ST_QLVL};
            ST_QOUT:  w = '{OP_OUT_SUM, HOLD_OUT,  COND_ALWAYS,   ST_IDLE};
            ST_QERR:  w = '{OP_OUT_ERR, HOLD_OUT,  COND_ALWAYS,   ST_IDLE};
            default:  w = '{OP_NOP,     HOLD_NONE, COND_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/stree_datapath.sv
// Node sum memory, query and update registers of the segment tree sum block.
module stree_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stree_pkg::dp_ctrl_t   ctrl,
    input  logic [10:0]           element_count,
    input  logic                  req_type,
    input  logic [9:0]            index,
    input  logic signed [31:0]    value,
    input  logic [9:0]            range_low,
    input  logic [9:0]            range_high,
    output stree_pkg::dp_status_t status,
    output logic [31:0]           sum
);
    import stree_pkg::*;

    localparam int NODES = 2 * MAX_ELEMENTS;
    localparam int MW    = $clog2(NODES);
    localparam int AW    = $clog2(NODES + 1);
    localparam int CAP   = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;

    localparam logic [MW-1:0] LEAF_BASE = MW'(MAX_ELEMENTS);
    localparam logic [MW-1:0] LAST_NODE = MW'(NODES - 1);
    localparam logic [AW-1:0] QBASE     = AW'(MAX_ELEMENTS);
    localparam logic [10:0]   COUNT_CAP = 11'(CAP);

    logic [31:0] mem [NODES];

    logic          req_reg,  req_next;
    logic [9:0]    idx_reg,  idx_next;
    logic [31:0]   val_reg,  val_next;
    logic [9:0]    lo_reg,   lo_next;
    logic [9:0]    hi_reg,   hi_next;
    logic [MW-1:0] clr_addr_reg, clr_addr_next;
    logic [MW-1:0] p_reg,    p_next;
    logic [31:0]   cur_reg,  cur_next;
    logic [AW-1:0] l_reg,    l_next;
    logic [AW-1:0] r_reg,    r_next;
    logic [31:0]   sum_reg,  sum_next;
    logic          take_a_reg, take_a_next;
    logic          take_b_reg, take_b_next;
    logic [31:0]   rd_a_reg, rd_b_reg;

    logic          mem_we;
    logic [MW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [MW-1:0] rd_a_addr, rd_b_addr;

    logic [MW-1:0] leaf, parent;
    logic [AW-1:0] r_dec;
    logic [31:0]   up_sum, add_a, add_b;
    logic [10:0]   eff_count;
    logic          l_lt_r;

    assign leaf      = LEAF_BASE + MW'(idx_reg);
    assign parent    = p_reg >> 1;
    assign r_dec     = r_reg - AW'(1);
    assign up_sum    = cur_reg + rd_a_reg;
    assign add_a     = take_a_reg ? rd_a_reg : '0;
    assign add_b     = take_b_reg ? rd_b_reg : '0;
    assign eff_count = (element_count > COUNT_CAP) ? COUNT_CAP : element_count;
    assign l_lt_r    = l_reg < r_reg;

    always_comb
    begin
        req_next      = req_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        clr_addr_next = clr_addr_reg;
        p_next        = p_reg;
        cur_next      = cur_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        sum_next      = sum_reg;
        take_a_next   = take_a_reg;
        take_b_next   = take_b_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        rd_a_addr     = l_reg[MW-1:0];
        rd_b_addr     = r_dec[MW-1:0];
        if (ctrl.go)
        begin
            case (ctrl.op)
                OP_CLR:
                begin
                    mem_we        = 1'b1;
                    clr_addr_next = clr_addr_reg + MW'(1);
                end
                OP_ACCEPT:
                begin
                    req_next = req_type;
                    idx_next = index;
                    val_next = value;
                    lo_next  = range_low;
                    hi_next  = range_high;
                end
                OP_WLEAF:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = leaf;
                    mem_wdata = val_reg;
                    p_next    = leaf;
                    cur_next  = val_reg;
                    rd_a_addr = leaf ^ MW'(1);
                end
                OP_WUP:
                begin
                    // The sibling read issued last step is ready now.
                    mem_we    = 1'b1;
                    mem_waddr = parent;
                    mem_wdata = up_sum;
                    p_next    = parent;
                    cur_next  = up_sum;
                    rd_a_addr = parent ^ MW'(1);
                end
                OP_QINIT:
                begin
                    l_next      = QBASE + AW'(lo_reg);
                    r_next      = QBASE + AW'(hi_reg) + AW'(1);
                    sum_next    = '0;
                    take_a_next = 1'b0;
                    take_b_next = 1'b0;
                end
                OP_QSTEP:
                begin
                    // Accumulate the nodes read for the previous level while
                    // issuing the reads of this one.
                    sum_next = sum_reg + add_a + add_b;
                    if (l_lt_r)
                    begin
                        take_a_next = l_reg[0];
                        take_b_next = r_reg[0];
                        l_next      = (l_reg + AW'(l_reg[0])) >> 1;
                        r_next      = (r_reg - AW'(r_reg[0])) >> 1;
                    end
                    else
                    begin
                        take_a_next = 1'b0;
                        take_b_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (ctrl.restart)
        begin
            clr_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            take_a_reg   <= 1'b0;
            take_b_reg   <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            take_a_reg   <= take_a_next;
            take_b_reg   <= take_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        p_reg   <= p_next;
        cur_reg <= cur_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign status.clr_more = clr_addr_reg != LAST_NODE;
    assign status.is_query = req_reg;
    assign status.bad      = req_reg ? ((lo_reg > hi_reg) || ({1'b0, hi_reg} >= eff_count))
                                     : ({1'b0, idx_reg} >= eff_count);
    assign status.not_top  = (p_reg >> 2) != '0;
    assign status.l_lt_r   = l_lt_r;
    assign sum             = sum_reg;

endmodule

// File: rtl/segment_tree_range_sum_top.sv
// A point write is finished, and a query result is loaded, before the next item is taken.
// One item is in work at a time; the pace is one tree level per microcode step, with the
// node memory read at two addresses per step. A finished result waits in an output register.
// After reset and each element_count write, a pass over all 2*MAX_ELEMENTS nodes zeroes the
// node memory; no item is taken during it. element_count resets to 1024.
module segment_tree_range_sum_top #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [9:0]         index,
    input  logic signed [31:0] value,
    input  logic [9:0]         range_low,
    input  logic [9:0]         range_high,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] range_sum,
    output logic               range_error
);
    import stree_pkg::*;

    step_t       upc_reg, upc_next;
    logic [10:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] range_sum_reg, range_sum_next;
    logic        range_error_reg, range_error_next;

    uword_t      uw;
    dp_ctrl_t    dp_ctrl;
    dp_status_t  dp_status;
    logic [31:0] dp_sum;
    logic        held, jump, cfg_wr, out_load;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);
    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {21'd0, count_reg} : '0;

    assign uw = ucode_rom(upc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_CLR_MORE: jump = dp_status.clr_more;
            COND_QUERY:    jump = dp_status.is_query;
            COND_BAD:      jump = dp_status.bad;
            COND_NOT_TOP:  jump = dp_status.not_top;
            COND_L_LT_R:   jump = dp_status.l_lt_r;
            default:       jump = 1'b0;
        endcase
    end

    assign held = ((uw.hold == HOLD_IN) && !in_valid)
               || ((uw.hold == HOLD_OUT) && out_valid_reg && !out_ready);

    assign in_ready        = uw.hold == HOLD_IN;
    assign dp_ctrl.op      = uw.op;
    assign dp_ctrl.go      = !held;
    assign dp_ctrl.restart = cfg_wr;
    assign out_load        = !held && ((uw.op == OP_OUT_SUM) || (uw.op == OP_OUT_ERR));

    always_comb
    begin
        if (cfg_wr)
        begin
            upc_next = ST_CLR;
        end
        else if (held)
        begin
            upc_next = upc_reg;
        end
        else if (jump)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg + step_t'(1);
        end

        count_next       = cfg_wr ? pwdata[10:0] : count_reg;
        out_valid_next   = out_load || (out_valid_reg && !out_ready);
        range_sum_next   = range_sum_reg;
        range_error_next = range_error_reg;
        if (out_load)
        begin
            range_error_next = uw.op == OP_OUT_ERR;
            range_sum_next   = (uw.op == OP_OUT_ERR) ? '0 : dp_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= ST_CLR;
            count_reg     <= 11'd1024;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_sum_reg   <= range_sum_next;
        range_error_reg <= range_error_next;
    end

    assign out_valid   = out_valid_reg;
    assign range_sum   = range_sum_reg;
    assign range_error = range_error_reg;

    stree_datapath #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (dp_ctrl),
        .element_count (count_reg),
        .req_type      (req_type),
        .index         (index),
        .value         (value),
        .range_low     (range_low),
        .range_high    (range_high),
        .status        (dp_status),
        .sum           (dp_sum)
    );

`ifndef ASSERT_OFF
    // A count write always restarts the clearing pass.
    a_cfg_restarts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (upc_reg == ST_CLR))
        else $error("clearing pass not restarted after count write");

    // An error result always carries a zero sum.
    a_error_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && range_error_reg) |-> (range_sum_reg == '0))
        else $error("error result with nonzero sum");

    // The step counter stays inside the program.
    a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= ST_QERR)
        else $error("step counter outside the program");

    // A result is only loaded once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule

// File: dv/segment_tree_range_sum_top_tb.sv
// Self-checking testbench for the segment tree range sum block with a scoreboard class.
module segment_tree_range_sum_top_tb;
    import stree_pkg::*;

    localparam int ELEMENTS = 1024;
    localparam int STUCK_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 235;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic [31:0] sum;
        logic        err;
    } sum_result_t;

    // Keeps a flat copy of the element array; a wrapped sum over a range of it equals
    // what the tree nodes add up to.
    class range_sum_scoreboard;
        logic [31:0]  elems [ELEMENTS];
        int unsigned  active_count;
        sum_result_t  expected_q [$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
            load_count(11'd1024);
        endfunction

        // A count write clears the whole array.
        function void load_count(logic [10:0] cnt);
            active_count = (cnt > ELEMENTS) ? ELEMENTS : cnt;
            foreach (elems[i])
                elems[i] = '0;
        endfunction

        function void note_request(logic rq, logic [9:0] idx, logic [31:0] val,
                                   logic [9:0] lo, logic [9:0] hi);
            sum_result_t res;
            if (rq == REQ_WRITE) begin
                if (idx < active_count)
                    elems[idx] = val;
            end else begin
                res.sum = '0;
                res.err = 1'b0;
                if (lo > hi || hi >= active_count)
                    res.err = 1'b1;
                else
                    for (int i = lo; i <= hi; i++)
                        res.sum = res.sum + elems[i];
                expected_q.push_back(res);
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [31:0] sum, logic err);
            sum_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result sum %0d error %0b",
                                          $signed(sum), err));
            end else begin
                want = expected_q.pop_front();
                if (sum !== want.sum)
                    report_mismatch($sformatf("range_sum got %0d expected %0d",
                                              $signed(sum), $signed(want.sum)));
                if (err !== want.err)
                    report_mismatch($sformatf("range_error got %0b expected %0b",
                                              err, want.err));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [9:0]         index;
    logic signed [31:0] value;
    logic [9:0]         range_low;
    logic [9:0]         range_high;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] range_sum;
    logic               range_error;

    logic               quiet;
    int unsigned        stuck_cycles = 0;
    range_sum_scoreboard sb;

    segment_tree_range_sum_top #(
        .MAX_ELEMENTS(ELEMENTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .index      (index),
        .value      (value),
        .range_low  (range_low),
        .range_high (range_high),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .range_sum  (range_sum),
        .range_error(range_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Presents one item and holds it until the block takes it. Valid is left high so
    // that the next item can follow without a gap.
    task automatic send_item(logic rq, logic [9:0] idx, logic [31:0] val,
                             logic [9:0] lo, logic [9:0] hi);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        index      <= idx;
        value      <= val;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(rq, idx, val, lo, hi);
    endtask

    task automatic do_write(logic [9:0] idx, logic [31:0] val);
        send_item(REQ_WRITE, idx, val, 10'($urandom()), 10'($urandom()));
    endtask

    task automatic do_query(logic [9:0] lo, logic [9:0] hi);
        send_item(REQ_QUERY, 10'($urandom()), $urandom(), lo, hi);
    endtask

    // Mostly in-range writes and well-formed queries, with some random noise.
    task automatic random_items(int unsigned n);
        int unsigned c;
        int unsigned a;
        int unsigned b;
        logic        rq;
        logic        noise;
        for (int k = 0; k < n; k++) begin
            c = sb.active_count;
            rq = 1'($urandom_range(0, 1));
            noise = (c == 0) || ($urandom_range(0, 9) == 0);
            if (noise) begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
                send_item(rq, 10'($urandom()), pick_value(), 10'(a), 10'(b));
            end else begin
                a = $urandom_range(0, c - 1);
                if ($urandom_range(0, 3) == 0) begin
                    b = a + $urandom_range(0, 3);
                    if (b >= c)
                        b = c - 1;
                end else begin
                    b = $urandom_range(0, c - 1);
                end
                if (a > b) begin
                    a = a ^ b;
                    b = a ^ b;
                    a = a ^ b;
                end
                send_item(rq, 10'($urandom_range(0, c - 1)), pick_value(), 10'(a), 10'(b));
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes may still be climbing the tree after the last result, so let them finish.
    task automatic reconfigure(logic [10:0] cnt);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_write({REG_ELEMENT_COUNT, 2'b00}, {21'b0, cnt});
        sb.load_count(cnt);
    endtask

    initial
    begin
        logic [10:0] counts [7];
        sb = new();
        quiet      <= 1'b0;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        req_type   <= REQ_WRITE;
        index      <= '0;
        value      <= '0;
        range_low  <= '0;
        range_high <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset count of 1024.
        do_query(10'd0, 10'd1023);
        do_write(10'd0, 32'h7FFF_FFFF);
        do_write(10'd1023, 32'h8000_0000);
        do_query(10'd0, 10'd1023);
        do_query(10'd1023, 10'd1023);
        do_write(10'd511, 32'hFFFF_FFFF);
        do_write(10'd512, 32'h0000_0001);
        do_query(10'd511, 10'd512);
        do_write(10'd1, 32'h7FFF_FFFF);
        do_query(10'd0, 10'd1);
        do_query(10'd0, 10'd0);
        do_query(10'd5, 10'd4);
        do_query(10'd1023, 10'd0);
        do_query(10'd0, 10'd511);
        do_query(10'd512, 10'd1023);
        do_write(10'd0, 32'h0000_0000);
        do_query(10'd0, 10'd0);
        do_write(10'd1023, 32'h7FFF_FFFF);
        do_query(10'd1022, 10'd1023);
        do_query(10'd1023, 10'd1023);
        random_items(PHASE_ITEMS);

        // Count of zero rejects everything; counts above the maximum saturate.
        counts = '{11'd1, 11'd2, 11'd0, 11'd2047, 11'd37, 11'($urandom_range(3, 1023)),
                   11'd1024};
        foreach (counts[i]) begin
            reconfigure(counts[i]);
            if (i == 6)
                quiet <= 1'b1;
            random_items(PHASE_ITEMS);
        end

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side backpressure: random stall bursts between ready stretches.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(range_sum, range_error);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
